// ===== design/gb3_pkg.sv =====
// shared types and constants for the 3x3 binomial blur
package gb3_pkg;

   localparam int PIXEL_BITS = 8;
   localparam int MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_SIZE = 3;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT);
   localparam int WIDTH_REG_BITS = COL_BITS + 1;
   localparam int HEIGHT_REG_BITS = ROW_BITS + 1;
   localparam int CSR_DATA_BITS = HEIGHT_REG_BITS;
   localparam int CSR_INDEX_BITS = 2;
   // kernel weights sum to 16, so the sum needs four bits more than a pixel
   localparam int SUM_BITS = PIXEL_BITS + 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = 11'd640;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd480;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

   typedef struct packed {
      logic [ROW_BITS-1:0]   out_row;
      logic [COL_BITS-1:0]   out_col;
      logic [PIXEL_BITS-1:0] out_value;
      logic                  last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] num;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== design/gb3_req_if.sv =====
// pixel input channel
interface gb3_req_if;
   logic                           valid;
   logic                           ready;
   logic [gb3_pkg::PIXEL_BITS-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

// ===== design/gb3_rsp_if.sv =====
// result channel
interface gb3_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gb3_pkg::ROW_BITS-1:0]   out_row;
   logic [gb3_pkg::COL_BITS-1:0]   out_col;
   logic [gb3_pkg::PIXEL_BITS-1:0] out_value;
   logic                           last_of_run;

   modport source (output valid, output out_row, output out_col, output out_value,
                   output last_of_run, input ready);
   modport sink (input valid, input out_row, input out_col, input out_value,
                 input last_of_run, output ready);
endinterface

// ===== design/gb3_rsp_queue.sv =====
// small result queue that takes up to two results per cycle and sends one beat per cycle while rsp_bus.ready is high
module gb3_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  gb3_pkg::push_type   push,
   output logic                room_two,
   gb3_rsp_if.source           rsp_bus
);

   gb3_pkg::result_type entries_ff [gb3_pkg::QUEUE_DEPTH];
   logic [gb3_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gb3_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gb3_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic [gb3_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_next;
   logic pop;
   gb3_pkg::result_type head;

   assign head = entries_ff[rd_ptr_ff];
   assign pop = rsp_bus.valid && rsp_bus.ready;
   assign room_two = count_ff <= gb3_pkg::QUEUE_CNT_BITS'(gb3_pkg::QUEUE_DEPTH - 2);
   assign wr_ptr_next = wr_ptr_ff + gb3_pkg::QUEUE_PTR_BITS'(1);

   assign rsp_bus.valid = count_ff != '0;
   assign rsp_bus.out_row = head.out_row;
   assign rsp_bus.out_col = head.out_col;
   assign rsp_bus.out_value = head.out_value;
   assign rsp_bus.last_of_run = head.last_of_run;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + gb3_pkg::QUEUE_PTR_BITS'(push.num);
      rd_ptr_in = rd_ptr_ff + gb3_pkg::QUEUE_PTR_BITS'(pop);
      count_in = count_ff + gb3_pkg::QUEUE_CNT_BITS'(push.num)
                 - gb3_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         entries_ff[wr_ptr_next] <= push.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> (count_ff + gb3_pkg::QUEUE_CNT_BITS'(push.num))
                           <= gb3_pkg::QUEUE_CNT_BITS'(gb3_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= gb3_pkg::QUEUE_CNT_BITS'(gb3_pkg::QUEUE_DEPTH))
      else $error("result queue count out of range");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      pop && push.num == 2'd0 |=> count_ff == $past(count_ff) - 1'b1)
      else $error("result queue count lost a pop");

endmodule

// ===== design/gaussian_blur_3x3.sv =====
// streaming 3x3 binomial blur over a raster-order pixel stream
//
// req_bus carries one pixel per beat in raster order; rsp_bus returns results, each
// with its row and column. a pixel at (r,c) yields the blurred interior pixel
// (r-1,c-1) when that one is interior, then a zero for (r,c) when it lies on the
// frame border; last_of_run marks the final result of a pixel. a pixel on which
// no result falls yields no beat.
// csr_we/csr_index/csr_wdata write frame_width (index 0) and frame_height
// (index 1), saturated to 3..1024 and 3..4096; a write restarts the frame at
// (0,0). write only while the block is idle.
// path: the first result of a pixel passes the stage 1 registers, then the result queue.
// throughput: one pixel per cycle while the queue has room for two, bounded by the
// single read/write port pair of the line memory and by the result port: a pixel with
// two results costs two output beats, absorbed by a four-entry result queue.
// reset: position (0,0), frame 640x480, window zeroed; line memory is not cleared.
// when rsp_bus stalls, the queue fills and req_bus.ready drops until room returns.
module gaussian_blur_3x3 (
   input  logic                                 clock,
   input  logic                                 reset,
   gb3_req_if.sink                              req_bus,
   gb3_rsp_if.source                            rsp_bus,
   input  logic                                 csr_we,
   input  logic [gb3_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gb3_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int PB = gb3_pkg::PIXEL_BITS;
   localparam int CB = gb3_pkg::COL_BITS;
   localparam int RB = gb3_pkg::ROW_BITS;
   localparam int WB = gb3_pkg::WIDTH_REG_BITS;
   localparam int HB = gb3_pkg::HEIGHT_REG_BITS;
   localparam int SB = gb3_pkg::SUM_BITS;

   // line memory: low byte is the previous row, high byte the row before it
   logic [2*PB-1:0] line_mem [gb3_pkg::MAX_WIDTH];
   logic [2*PB-1:0] line_rd_ff;

   logic [WB-1:0] width_ff, width_in;
   logic [HB-1:0] height_ff, height_in;
   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;

   logic          s1_valid_ff, s1_valid_in;
   logic [PB-1:0] s1_pixel_ff;
   logic [CB-1:0] s1_col_ff;
   logic [RB-1:0] s1_row_ff;
   logic          s1_interior_ff;
   logic          s1_border_ff;

   logic [PB-1:0] win_ff [6];

   logic accept, s1_go, room_two, restart;
   logic col_wrap, row_wrap, interior, border;
   logic [WB-1:0] wdata_width;
   logic [HB-1:0] wdata_height;
   logic [PB-1:0] top, mid;
   logic [SB-1:0] sum;
   gb3_pkg::result_type res_int, res_bdr;
   gb3_pkg::push_type push;

   assign accept = req_bus.valid && req_bus.ready;
   assign s1_go = s1_valid_ff && room_two;
   assign req_bus.ready = !s1_valid_ff || s1_go;

   // configuration
   assign wdata_width = csr_wdata[WB-1:0];
   assign wdata_height = csr_wdata[HB-1:0];

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      restart = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            gb3_pkg::CSR_FRAME_WIDTH: begin
               restart = 1'b1;
               if (wdata_width < WB'(gb3_pkg::MIN_SIZE)) begin
                  width_in = WB'(gb3_pkg::MIN_SIZE);
               end else if (wdata_width > WB'(gb3_pkg::MAX_WIDTH)) begin
                  width_in = WB'(gb3_pkg::MAX_WIDTH);
               end else begin
                  width_in = wdata_width;
               end
            end
            gb3_pkg::CSR_FRAME_HEIGHT: begin
               restart = 1'b1;
               if (wdata_height < HB'(gb3_pkg::MIN_SIZE)) begin
                  height_in = HB'(gb3_pkg::MIN_SIZE);
               end else if (wdata_height > HB'(gb3_pkg::MAX_HEIGHT)) begin
                  height_in = HB'(gb3_pkg::MAX_HEIGHT);
               end else begin
                  height_in = wdata_height;
               end
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // raster position of the next pixel
   always_comb begin
      col_wrap = ({1'b0, col_ff} + WB'(1)) >= width_ff;
      row_wrap = ({1'b0, row_ff} + HB'(1)) >= height_ff;
      interior = (row_ff >= RB'(2)) && (col_ff >= CB'(2));
      border = (row_ff == '0) || ({1'b0, row_ff} == height_ff - HB'(1)) ||
               (col_ff == '0) || ({1'b0, col_ff} == width_ff - WB'(1));
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + RB'(1);
         end else begin
            col_in = col_ff + CB'(1);
         end
      end
      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= gb3_pkg::WIDTH_RESET;
         height_ff <= gb3_pkg::HEIGHT_RESET;
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         col_ff <= col_in;
         row_ff <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // stage 1 payload, loaded together with the memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_bus.pixel;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
         s1_interior_ff <= interior;
         s1_border_ff <= border;
      end
   end

   // consecutive pixels never share a column, so the write-back cannot collide
   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[col_ff];
      end
      if (s1_go) begin
         line_mem[s1_col_ff] <= {mid, s1_pixel_ff};
      end
   end

   assign mid = line_rd_ff[PB-1:0];
   assign top = line_rd_ff[2*PB-1:PB];

   // window: entries 0..2 column c-1 top to bottom, 3..5 column c-2
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_go) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= top;
         win_ff[1] <= mid;
         win_ff[2] <= s1_pixel_ff;
      end
   end

   always_comb begin
      sum = SB'(win_ff[3]) + (SB'(win_ff[0]) << 1) + SB'(top)
          + (SB'(win_ff[4]) << 1) + (SB'(win_ff[1]) << 2) + (SB'(mid) << 1)
          + SB'(win_ff[5]) + (SB'(win_ff[2]) << 1) + SB'(s1_pixel_ff);
      // sum + 8 stays below 16 * 2^PB, so the rounded value never needs a clamp
      sum = sum + SB'(8);

      res_int.out_row = s1_row_ff - RB'(1);
      res_int.out_col = s1_col_ff - CB'(1);
      res_int.out_value = sum[SB-1:4];
      res_int.last_of_run = !s1_border_ff;

      res_bdr.out_row = s1_row_ff;
      res_bdr.out_col = s1_col_ff;
      res_bdr.out_value = '0;
      res_bdr.last_of_run = 1'b1;

      push.num = 2'd0;
      push.first = res_int;
      push.second = res_bdr;
      if (s1_go) begin
         if (s1_interior_ff && s1_border_ff) begin
            push.num = 2'd2;
         end else if (s1_interior_ff) begin
            push.num = 2'd1;
         end else if (s1_border_ff) begin
            push.num = 2'd1;
            push.first = res_bdr;
         end
      end
   end

   gb3_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room_two (room_two),
      .rsp_bus  (rsp_bus)
   );

   a_accept_loads_s1: assert property (@(posedge clock) disable iff (reset)
      accept && !restart |=> s1_valid_ff)
      else $error("accepted pixel did not reach stage 1");

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < width_ff)
      else $error("column counter outside frame width");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} < height_ff)
      else $error("row counter outside frame height");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.num == 2'd2 |-> !push.first.last_of_run && push.second.last_of_run)
      else $error("interior and border results out of order");

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the streaming 3x3 binomial blur
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_CYCLES = 120;
   localparam int RANDOM_ITEMS = 400;
   localparam int unsigned PIXEL_MAX = (1 << gb3_pkg::PIXEL_BITS) - 1;
   localparam logic [gb3_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [gb3_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_HI = 2'd3;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_we = 1'b0;
   logic [gb3_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [gb3_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   gb3_req_if req_bus ();
   gb3_rsp_if rsp_bus ();

   gaussian_blur_3x3 dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // blur predictor state
   logic [gb3_pkg::WIDTH_REG_BITS-1:0]  width_reg;
   logic [gb3_pkg::HEIGHT_REG_BITS-1:0] height_reg;
   logic [gb3_pkg::PIXEL_BITS-1:0]      prev_line [gb3_pkg::MAX_WIDTH];
   logic [gb3_pkg::PIXEL_BITS-1:0]      prev_line2 [gb3_pkg::MAX_WIDTH];
   logic [gb3_pkg::PIXEL_BITS-1:0]      win_px [6];
   int unsigned                         row_pos;
   int unsigned                         col_pos;
   gb3_pkg::result_type                 blur_expect [$];
   gb3_pkg::result_type                 blur_want;

   logic [gb3_pkg::PIXEL_BITS-1:0] pixel_queue [$];
   int unsigned pixels_queued = 0;
   int unsigned pixels_taken = 0;
   int unsigned errors = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle = 0;
   int unsigned recv_idle = 0;
   int unsigned stall_orders = 0;
   int unsigned stall_served = 0;
   int unsigned stall_left = 0;
   logic        req_taken = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic blur_pixel(input logic [gb3_pkg::PIXEL_BITS-1:0] px);
      int unsigned w, h, r, c, top, mid, acc, val;
      logic        interior, border;
      gb3_pkg::result_type res;
      w = (width_reg < gb3_pkg::MIN_SIZE) ? gb3_pkg::MIN_SIZE :
          (width_reg > gb3_pkg::MAX_WIDTH) ? gb3_pkg::MAX_WIDTH : width_reg;
      h = (height_reg < gb3_pkg::MIN_SIZE) ? gb3_pkg::MIN_SIZE :
          (height_reg > gb3_pkg::MAX_HEIGHT) ? gb3_pkg::MAX_HEIGHT : height_reg;
      r = (row_pos >= h) ? h - 1 : row_pos;
      c = (col_pos >= w) ? w - 1 : col_pos;
      top = 32'(prev_line2[c]);
      mid = 32'(prev_line[c]);
      interior = (r >= 2) && (c >= 2);
      border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
      if (interior) begin
         acc = win_px[3] + 2 * win_px[0] + top
             + 2 * win_px[4] + 4 * win_px[1] + 2 * mid
             + win_px[5] + 2 * win_px[2] + px;
         val = (acc + 8) >> 4;
         if (val > PIXEL_MAX)
            val = PIXEL_MAX;
         res.out_row = gb3_pkg::ROW_BITS'(r - 1);
         res.out_col = gb3_pkg::COL_BITS'(c - 1);
         res.out_value = gb3_pkg::PIXEL_BITS'(val);
         res.last_of_run = !border;
         blur_expect = {blur_expect, res};
      end
      if (border) begin
         res.out_row = gb3_pkg::ROW_BITS'(r);
         res.out_col = gb3_pkg::COL_BITS'(c);
         res.out_value = '0;
         res.last_of_run = 1'b1;
         blur_expect = {blur_expect, res};
      end
      prev_line2[c] = gb3_pkg::PIXEL_BITS'(mid);
      prev_line[c] = px;
      win_px[3] = win_px[0];
      win_px[4] = win_px[1];
      win_px[5] = win_px[2];
      win_px[0] = gb3_pkg::PIXEL_BITS'(top);
      win_px[1] = gb3_pkg::PIXEL_BITS'(mid);
      win_px[2] = px;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // monitor: register writes, accepted pixels and result beats, all at the rising edge
   always @(posedge clock) begin
      req_taken = !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               gb3_pkg::CSR_FRAME_WIDTH: begin
                  width_reg = csr_wdata[gb3_pkg::WIDTH_REG_BITS-1:0];
                  row_pos = 0;
                  col_pos = 0;
               end
               gb3_pkg::CSR_FRAME_HEIGHT: begin
                  height_reg = csr_wdata[gb3_pkg::HEIGHT_REG_BITS-1:0];
                  row_pos = 0;
                  col_pos = 0;
               end
               default: ;
            endcase
         end
         if (req_taken) begin
            blur_pixel(req_bus.pixel);
            pixels_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (blur_expect.size() == 0) begin
               $error("result beat with nothing expected: row %0d col %0d value %0d",
                      rsp_bus.out_row, rsp_bus.out_col, rsp_bus.out_value);
               errors++;
            end else begin
               blur_want = blur_expect.pop_front();
               check_field("out_row", 32'(blur_want.out_row), 32'(rsp_bus.out_row));
               check_field("out_col", 32'(blur_want.out_col), 32'(rsp_bus.out_col));
               check_field("out_value", 32'(blur_want.out_value), 32'(rsp_bus.out_value));
               check_field("last_of_run", 32'(blur_want.last_of_run),
                           32'(rsp_bus.last_of_run));
            end
         end
      end
   end

   // pixel driver: holds a beat until taken, idles at random between beats
   always @(negedge clock) begin
      if (!req_bus.valid || req_taken) begin
         if (!reset && pixel_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_bus.valid <= 1'b1;
            req_bus.pixel <= pixel_queue.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
            req_bus.pixel <= gb3_pkg::PIXEL_BITS'($urandom);
         end
      end
   end

   // result receiver with random idling and long hold-offs on request
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_orders != stall_served) begin
         stall_served++;
         stall_left = STALL_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic queue_pixel(input logic [gb3_pkg::PIXEL_BITS-1:0] px);
      pixel_queue = {pixel_queue, px};
      pixels_queued++;
   endtask

   function automatic logic [gb3_pkg::PIXEL_BITS-1:0] random_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return gb3_pkg::PIXEL_BITS'(PIXEL_MAX);
         default: return gb3_pkg::PIXEL_BITS'($urandom_range(PIXEL_MAX));
      endcase
   endfunction

   task automatic write_csr(input logic [gb3_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [gb3_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_results();
      do
         @(negedge clock);
      while (pixels_taken != pixels_queued || blur_expect.size() != 0);
   endtask

   // a pixel with no result may still be in flight after the last result
   task automatic settle();
      wait_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned n, half, w_eff, h_eff, wv, hv, random_sent, phase;
      logic [gb3_pkg::CSR_DATA_BITS-1:0] wdata;
      for (int i = 0; i < gb3_pkg::MAX_WIDTH; i++) begin
         prev_line[i] = '0;
         prev_line2[i] = '0;
      end
      for (int i = 0; i < 6; i++)
         win_px[i] = '0;
      width_reg = gb3_pkg::WIDTH_RESET;
      height_reg = gb3_pkg::HEIGHT_RESET;
      row_pos = 0;
      col_pos = 0;
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      rsp_bus.ready = 1'b0;
      send_idle = 38;
      recv_idle = 52;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // smallest frame, all pixels at full scale, then a frame that wraps
      write_csr(gb3_pkg::CSR_FRAME_WIDTH, gb3_pkg::CSR_DATA_BITS'(3));
      write_csr(gb3_pkg::CSR_FRAME_HEIGHT, gb3_pkg::CSR_DATA_BITS'(3));
      @(posedge clock);
      repeat (9) queue_pixel(gb3_pkg::PIXEL_BITS'(PIXEL_MAX));
      queue_pixel(8'h01);
      queue_pixel(8'h80);
      queue_pixel(8'h7f);
      queue_pixel(8'hfe);
      settle();
      // unused register indexes must not restart the frame
      write_csr(CSR_UNUSED_LO, '1);
      write_csr(CSR_UNUSED_HI, '0);
      @(posedge clock);
      repeat (4) queue_pixel('0);
      queue_pixel(gb3_pkg::PIXEL_BITS'(PIXEL_MAX));
      settle();
      // below-range width and above-range height saturate
      write_csr(gb3_pkg::CSR_FRAME_WIDTH, gb3_pkg::CSR_DATA_BITS'(1));
      write_csr(gb3_pkg::CSR_FRAME_HEIGHT, '1);
      @(posedge clock);
      repeat (9) queue_pixel(random_pixel());
      settle();

      // widest frame: the start of the top row
      write_csr(gb3_pkg::CSR_FRAME_WIDTH, gb3_pkg::CSR_DATA_BITS'(2047));
      write_csr(gb3_pkg::CSR_FRAME_HEIGHT, gb3_pkg::CSR_DATA_BITS'(2));
      @(posedge clock);
      repeat (8) queue_pixel(random_pixel());
      settle();

      w_eff = 3;
      h_eff = gb3_pkg::MAX_HEIGHT;
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         wv = $urandom_range(9, 3);
         hv = $urandom_range(6, 3);
         case ($urandom_range(9))
            0: begin
               wdata = gb3_pkg::CSR_DATA_BITS'($urandom_range(2));
               w_eff = 3;
            end
            1: begin
               // bits above the width register are dropped
               wdata = {2'($urandom_range(3, 1)), 11'(wv)};
               w_eff = wv;
            end
            default: begin
               wdata = gb3_pkg::CSR_DATA_BITS'(wv);
               w_eff = wv;
            end
         endcase
         write_csr(gb3_pkg::CSR_FRAME_WIDTH, wdata);
         if ($urandom_range(3) != 0) begin
            if ($urandom_range(7) == 0) begin
               write_csr(gb3_pkg::CSR_FRAME_HEIGHT,
                         gb3_pkg::CSR_DATA_BITS'($urandom_range(2)));
               h_eff = 3;
            end else begin
               write_csr(gb3_pkg::CSR_FRAME_HEIGHT, gb3_pkg::CSR_DATA_BITS'(hv));
               h_eff = hv;
            end
         end
         if (h_eff > 6)
            h_eff = 6;
         n = w_eff * h_eff * $urandom_range(2, 1) + $urandom_range(2 * w_eff);
         if (phase == 1)
            n += 40;
         if (random_sent < RANDOM_ITEMS / 3) begin
            send_idle = 38;
            recv_idle = 52;
         end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle = 52;
            recv_idle = 38;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         @(posedge clock);
         half = n / 2;
         repeat (half) queue_pixel(random_pixel());
         if (phase == 1)
            stall_orders++;
         if (phase == 2) begin
            // sender pauses mid-frame until every result is back
            wait_results();
            @(posedge clock);
         end
         repeat (n - half) queue_pixel(random_pixel());
         random_sent += n;
         phase++;
         settle();
      end

      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
